// ----- rtl/assert_macros.svh -----
//------------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, disabled while arst_n is low.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop holds at every edge
`define VNA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// pre at one edge implies post at the next
`define VNA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);

`endif

// ----- rtl/vna_pkg.sv -----
//------------------------------------------------------------------------------
// vna_pkg
// Shared widths, codes and storage types of the vertex normal averager.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package vna_pkg;

	localparam int IDX_W      = 10;
	localparam int SLOTS      = 1 << IDX_W;
	localparam int COORD_W    = 24;
	localparam int NRM_W      = 16;
	localparam int CNT_W      = 16;
	localparam int SUM_W      = 32;
	localparam int S_DATA_W   = 112;
	localparam int S_USER_W   = 2;
	localparam int M_DATA_W   = 64;
	localparam int MAX_VERTICES_DEF = 1024;

	localparam int EDGE_W     = COORD_W + 1;
	localparam int CROSS_W    = 52;
	localparam int MAG_W      = CROSS_W - 1;
	localparam int AMAG_W     = 30;
	localparam int MUL_W      = AMAG_W + 1;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int RAD_W      = 62;
	localparam int ROOT_W     = 31;
	localparam int DVD_W      = AMAG_W + 14;
	localparam int DSR_W      = ROOT_W;
	localparam int QUO_W      = 15;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_TRI  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} pos_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] sz;
		logic [CNT_W-1:0]        cnt;
	} acc_t;

endpackage

// ----- rtl/vna_mul.sv -----
//------------------------------------------------------------------------------
// vna_mul
// Shared signed multiplier with a registered product.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module vna_mul (
	input  logic                               clk,
	input  logic signed [vna_pkg::MUL_W-1:0]   a,
	input  logic signed [vna_pkg::MUL_W-1:0]   b,
	output logic signed [vna_pkg::PROD_W-1:0]  p_q
);
	import vna_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// ----- rtl/vna_isqrt.sv -----
//------------------------------------------------------------------------------
// vna_isqrt
// Integer square root, one result bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module vna_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vna_pkg::RAD_W-1:0]    n,
	output logic                         done,
	output logic [vna_pkg::ROOT_W-1:0]   root
);
	import vna_pkg::*;

	logic [RAD_W-1:0] rem_q;
	logic [RAD_W:0]   res_q;
	logic [RAD_W:0]   bit_q;
	logic             busy_q;
	logic             done_q;
	logic [RAD_W:0]   trial;
	logic             ge;

	assign trial = res_q + bit_q;
	assign ge    = {1'b0, rem_q} >= trial;
	assign done  = done_q;
	assign root  = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= n;
			res_q <= '0;
			bit_q <= {1'b1, {RAD_W{1'b0}}};
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= RAD_W'({1'b0, rem_q} - trial);
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ----- rtl/vna_div.sv -----
//------------------------------------------------------------------------------
// vna_div
// Restoring divider, one quotient bit per cycle, 15-bit quotient.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module vna_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vna_pkg::DVD_W-1:0]    dividend,
	input  logic [vna_pkg::DSR_W-1:0]    divisor,
	output logic                         done,
	output logic [vna_pkg::QUO_W-1:0]    quotient
);
	import vna_pkg::*;

	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [QUO_W-1:0] lo_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   trial;
	logic             ge;

	assign trial    = {rem_q, lo_q[QUO_W-1]};
	assign ge       = trial >= {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DSR_W'(dividend[DVD_W-1:QUO_W]);
			lo_q  <= dividend[QUO_W-1:0];
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= DSR_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[DSR_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			lo_q  <= lo_q << 1;
		end
	end

endmodule

// ----- rtl/vertex_normal_averager.sv -----
//------------------------------------------------------------------------------
// vertex_normal_averager
// Per-vertex normal accumulation of a triangle mesh with a shared sequencer.
//------------------------------------------------------------------------------
// Input items arrive on s_axis; the kind travels in tuser: load vertex, add
// triangle, read vertex normal. Only a read returns an item, on m_axis.
// A triangle keeps the block busy through three position reads, six products
// on the shared multiplier, a right shift of the magnitudes by up to 21 bits,
// three squares, a square root, three 15-bit divisions, then a
// read-modify-write of each corner's sum and count. A degenerate triangle
// skips the divisions. A read runs three divisions of the sums by the count
// on the same divider, or none when the vertex has no faces.
// s_axis_tready is high only while the sequencer is idle, so one item is in
// work at a time.
// The result sits in an output register; a stalled receiver holds it, and a
// following read waits for that register before it finishes.
// Reset clears the sequencer and the output valid; vertex storage is not
// cleared and must be loaded before use.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_normal_averager #(
	parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// vtx_idx, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
	input  logic [vna_pkg::S_DATA_W-1:0]     s_axis_tdata,
	// action
	input  logic [vna_pkg::S_USER_W-1:0]     s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// normal_x, normal_y, normal_z, face_count
	output logic [vna_pkg::M_DATA_W-1:0]     m_axis_tdata
);
	import vna_pkg::*;
	`include "assert_macros.svh"

	localparam logic [16:0] MaxV = 17'(MAX_VERTICES);

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_POS_A   = 17'h00002,
		S_POS_B   = 17'h00004,
		S_POS_C   = 17'h00008,
		S_POS_D   = 17'h00010,
		S_CROSS   = 17'h00020,
		S_MAGS    = 17'h00040,
		S_NORM    = 17'h00080,
		S_SQUARE  = 17'h00100,
		S_ROOT    = 17'h00200,
		S_DIVIDE  = 17'h00400,
		S_ADD_RD  = 17'h00800,
		S_ADD_WR  = 17'h01000,
		S_RD_ACC  = 17'h02000,
		S_RD_DATA = 17'h04000,
		S_RD_DIV  = 17'h08000,
		S_RD_FIN  = 17'h10000
	} state_t;

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		in_range = {7'd0, idx} < MaxV;
	endfunction

	state_t state_q;

	logic [1:0]       s_act;
	logic [IDX_W-1:0] s_vi;
	pos_t             s_pos;
	logic [IDX_W-1:0] s_cor [3];
	logic             accept;

	logic [IDX_W-1:0] vi_q;
	logic             vi_ok_q;
	logic [IDX_W-1:0] cor_q [3];

	pos_t             pos_mem [SLOTS];
	acc_t             acc_mem [SLOTS];
	pos_t             pos_rd_q;
	acc_t             acc_rd_q;
	logic [IDX_W-1:0] pos_raddr;
	logic [IDX_W-1:0] acc_raddr;
	logic             pos_we;
	logic             acc_we;
	logic [IDX_W-1:0] acc_waddr;
	acc_t             acc_wdata;

	pos_t                    pa_q;
	pos_t                    pb_q;
	logic signed [EDGE_W-1:0]  e1_q [3];
	logic signed [EDGE_W-1:0]  e2_q [3];
	logic signed [CROSS_W-1:0] cr_q [3];
	logic [MAG_W-1:0]          m_q [3];
	logic                      neg_q [3];
	logic [RAD_W-1:0]          sq_q;
	logic [ROOT_W-1:0]         len_q;
	logic signed [NRM_W-1:0]   nrm_q [3];
	logic signed [SUM_W-1:0]   rs_q [3];
	logic [CNT_W-1:0]          rcnt_q;
	logic [2:0]                step_q;
	logic [1:0]                comp_q;
	logic [1:0]                cidx_q;
	logic                      sqrt_go_q;
	logic                      div_go_q;

	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [CROSS_W-1:0] prod_c;
	logic [1:0]                pidx;
	logic [1:0]                sidx;

	logic                      sqrt_done;
	logic [ROOT_W-1:0]         root;
	logic                      div_done;
	logic [QUO_W-1:0]          quo;
	logic [DVD_W-1:0]          dvd;
	logic [DSR_W-1:0]          dsr;
	logic [SUM_W-1:0]          rmag;
	logic                      qneg;
	logic signed [NRM_W-1:0]   qval;

	logic                      m_valid_q;
	logic [M_DATA_W-1:0]       m_data_q;

	assign s_act    = s_axis_tuser;
	assign s_vi     = s_axis_tdata[9:0];
	assign s_pos.x  = s_axis_tdata[33:10];
	assign s_pos.y  = s_axis_tdata[57:34];
	assign s_pos.z  = s_axis_tdata[81:58];
	assign s_cor[0] = s_axis_tdata[91:82];
	assign s_cor[1] = s_axis_tdata[101:92];
	assign s_cor[2] = s_axis_tdata[111:102];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// storage
	assign pos_we    = accept && (s_act == ACT_LOAD) && in_range(s_vi);
	assign acc_we    = pos_we || ((state_q == S_ADD_WR) && (acc_rd_q.cnt != CNT_MAX));
	assign acc_waddr = pos_we ? s_vi : cor_q[cidx_q];

	always_comb begin
		acc_wdata.sx  = acc_rd_q.sx + SUM_W'(nrm_q[0]);
		acc_wdata.sy  = acc_rd_q.sy + SUM_W'(nrm_q[1]);
		acc_wdata.sz  = acc_rd_q.sz + SUM_W'(nrm_q[2]);
		acc_wdata.cnt = acc_rd_q.cnt + CNT_W'(1);
		if (pos_we) begin
			acc_wdata = '0;
		end
	end

	always_comb begin
		unique case (state_q)
			S_POS_A: pos_raddr = cor_q[0];
			S_POS_B: pos_raddr = cor_q[1];
			default: pos_raddr = cor_q[2];
		endcase
	end

	assign acc_raddr = (state_q == S_ADD_RD) ? cor_q[cidx_q] : vi_q;

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[s_vi] <= s_pos;
		end
		pos_rd_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		acc_rd_q <= acc_mem[acc_raddr];
	end

	// shared multiplier operands
	always_comb begin
		sidx = step_q[1:0];
		mul_a = MUL_W'(e1_q[1]);
		mul_b = MUL_W'(e2_q[2]);
		if (state_q == S_SQUARE) begin
			mul_a = MUL_W'({1'b0, m_q[sidx][AMAG_W-1:0]});
			mul_b = mul_a;
		end else begin
			case (step_q)
				3'd1: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
				3'd2: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
				3'd3: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
				3'd4: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
				3'd5: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
				default: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
			endcase
		end
	end

	vna_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	assign prod_c = CROSS_W'(prod_q);
	assign pidx   = 2'((step_q - 3'd1) >> 1);

	vna_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_go_q),
		.n      (sq_q),
		.done   (sqrt_done),
		.root   (root)
	);

	// divider operands
	always_comb begin
		rmag = rs_q[comp_q][SUM_W-1] ? SUM_W'(-rs_q[comp_q]) : SUM_W'(rs_q[comp_q]);
		if (state_q == S_RD_DIV) begin
			dvd  = DVD_W'(rmag);
			dsr  = DSR_W'(rcnt_q);
			qneg = rs_q[comp_q][SUM_W-1];
		end else begin
			dvd  = {m_q[comp_q][AMAG_W-1:0], 14'd0};
			dsr  = len_q;
			qneg = neg_q[comp_q];
		end
		qval = qneg ? -NRM_W'(quo) : NRM_W'(quo);
	end

	vna_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (dvd),
		.divisor  (dsr),
		.done     (div_done),
		.quotient (quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			m_valid_q <= 1'b0;
			step_q    <= '0;
			comp_q    <= '0;
			cidx_q    <= '0;
		end else begin
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (s_act)
							ACT_TRI: begin
								if (in_range(s_cor[0]) && in_range(s_cor[1]) &&
										in_range(s_cor[2])) begin
									state_q <= S_POS_A;
								end
							end
							ACT_READ: state_q <= S_RD_ACC;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_POS_A: state_q <= S_POS_B;
				S_POS_B: state_q <= S_POS_C;
				S_POS_C: state_q <= S_POS_D;
				S_POS_D: begin
					step_q  <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						state_q <= S_MAGS;
					end
				end
				S_MAGS: state_q <= S_NORM;
				S_NORM: begin
					if (!((|m_q[0][MAG_W-1:AMAG_W]) || (|m_q[1][MAG_W-1:AMAG_W]) ||
							(|m_q[2][MAG_W-1:AMAG_W]))) begin
						step_q  <= '0;
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd3) begin
						sqrt_go_q <= 1'b1;
						state_q   <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (sqrt_done) begin
						comp_q <= '0;
						cidx_q <= '0;
						if (root == '0) begin
							state_q <= S_ADD_RD;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= S_DIVIDE;
						end
					end
				end
				S_DIVIDE: begin
					if (div_done) begin
						if (comp_q == 2'd2) begin
							cidx_q  <= '0;
							state_q <= S_ADD_RD;
						end else begin
							comp_q   <= comp_q + 2'd1;
							div_go_q <= 1'b1;
						end
					end
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					cidx_q <= cidx_q + 2'd1;
					state_q <= (cidx_q == 2'd2) ? S_IDLE : S_ADD_RD;
				end
				S_RD_ACC: state_q <= S_RD_DATA;
				S_RD_DATA: begin
					comp_q <= '0;
					if (vi_ok_q && (acc_rd_q.cnt != '0)) begin
						div_go_q <= 1'b1;
						state_q  <= S_RD_DIV;
					end else begin
						state_q <= S_RD_FIN;
					end
				end
				S_RD_DIV: begin
					if (div_done) begin
						if (comp_q == 2'd2) begin
							state_q <= S_RD_FIN;
						end else begin
							comp_q   <= comp_q + 2'd1;
							div_go_q <= 1'b1;
						end
					end
				end
				S_RD_FIN: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			vi_q    <= s_vi;
			vi_ok_q <= in_range(s_vi);
			cor_q   <= s_cor;
		end
		if (state_q == S_POS_B) begin
			pa_q <= pos_rd_q;
		end
		if (state_q == S_POS_C) begin
			pb_q <= pos_rd_q;
		end
		if (state_q == S_POS_D) begin
			e1_q[0] <= EDGE_W'(pb_q.x) - EDGE_W'(pa_q.x);
			e1_q[1] <= EDGE_W'(pb_q.y) - EDGE_W'(pa_q.y);
			e1_q[2] <= EDGE_W'(pb_q.z) - EDGE_W'(pa_q.z);
			e2_q[0] <= EDGE_W'(pos_rd_q.x) - EDGE_W'(pa_q.x);
			e2_q[1] <= EDGE_W'(pos_rd_q.y) - EDGE_W'(pa_q.y);
			e2_q[2] <= EDGE_W'(pos_rd_q.z) - EDGE_W'(pa_q.z);
		end
		if ((state_q == S_CROSS) && (step_q != 3'd0)) begin
			if (step_q[0]) begin
				cr_q[pidx] <= prod_c;
			end else begin
				cr_q[pidx] <= cr_q[pidx] - prod_c;
			end
		end
		if (state_q == S_MAGS) begin
			for (int k = 0; k < 3; k++) begin
				m_q[k]   <= cr_q[k][CROSS_W-1] ? MAG_W'(-cr_q[k]) : MAG_W'(cr_q[k]);
				neg_q[k] <= cr_q[k][CROSS_W-1];
			end
		end
		if (state_q == S_NORM) begin
			if ((|m_q[0][MAG_W-1:AMAG_W]) || (|m_q[1][MAG_W-1:AMAG_W]) ||
					(|m_q[2][MAG_W-1:AMAG_W])) begin
				for (int k = 0; k < 3; k++) begin
					m_q[k] <= m_q[k] >> 1;
				end
			end
		end
		if ((state_q == S_SQUARE) && (step_q != 3'd0)) begin
			if (step_q == 3'd1) begin
				sq_q <= RAD_W'(prod_q);
			end else begin
				sq_q <= sq_q + RAD_W'(prod_q);
			end
		end
		if ((state_q == S_ROOT) && sqrt_done) begin
			len_q <= root;
			if (root == '0) begin
				nrm_q[0] <= '0;
				nrm_q[1] <= '0;
				nrm_q[2] <= '0;
			end
		end
		if (((state_q == S_DIVIDE) || (state_q == S_RD_DIV)) && div_done) begin
			nrm_q[comp_q] <= qval;
		end
		if (state_q == S_RD_DATA) begin
			rs_q[0] <= acc_rd_q.sx;
			rs_q[1] <= acc_rd_q.sy;
			rs_q[2] <= acc_rd_q.sz;
			rcnt_q  <= vi_ok_q ? acc_rd_q.cnt : '0;
			if (!(vi_ok_q && (acc_rd_q.cnt != '0))) begin
				nrm_q[0] <= '0;
				nrm_q[1] <= '0;
				nrm_q[2] <= '0;
			end
		end
		if ((state_q == S_RD_FIN) && (!m_valid_q || m_axis_tready)) begin
			m_data_q <= {rcnt_q, nrm_q[2], nrm_q[1], nrm_q[0]};
		end
	end

	`VNA_ASSERT(a_div_owner, div_done |-> (state_q == S_DIVIDE || state_q == S_RD_DIV), "divider done outside a divide state")
	`VNA_ASSERT(a_root_owner, sqrt_done |-> (state_q == S_ROOT), "square root done outside root state")
	`VNA_ASSERT_NEXT(a_fin_load, (state_q == S_RD_FIN && (!m_valid_q || m_axis_tready)), (m_valid_q && state_q == S_IDLE), "read item not presented")

endmodule
